// ----- src/tscd_pkg.sv -----
// Shared types and character constants for the text space collapse and char reference decoder.
`default_nettype none

package tscd_pkg;

  localparam int unsigned CharW = 16;

  localparam logic [CharW-1:0] CH_TAB   = 16'h0009;
  localparam logic [CharW-1:0] CH_LF    = 16'h000A;
  localparam logic [CharW-1:0] CH_CR    = 16'h000D;
  localparam logic [CharW-1:0] CH_SPACE = 16'h0020;
  localparam logic [CharW-1:0] CH_HASH  = 16'h0023;
  localparam logic [CharW-1:0] CH_AMP   = 16'h0026;
  localparam logic [CharW-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CharW-1:0] CH_NINE  = 16'h0039;
  localparam logic [CharW-1:0] CH_SEMI  = 16'h003B;

  localparam int unsigned QueueDepth = 3;

  // Register index decode on the configuration port.
  localparam logic REG_PRE_MODE = 1'b0;

  typedef enum logic [1:0] {
    PH_TEXT      = 2'd0,
    PH_AMP       = 2'd1,
    PH_HASH      = 2'd2,
    PH_SEMI_ONLY = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [CharW-1:0] code;
    logic             prev_lf;
    logic             space_seen;
    logic             cr_pend;
  } dec_state_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             vld;
    logic             last;
  } res_t;

  // Results produced by one character: a count of zero, one or two, then the results in order.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } core_out_t;

endpackage

`default_nettype wire

// ----- src/text_space_collapse_char_ref_decode.sv -----
// Top level of the text whitespace normalizer with numeric character reference decoding.
`default_nettype none

// The block takes one 16-bit text character per transfer on the in_ stream, with tlast on the
// final character of a string, and returns its normalized text on the out_ stream. With
// pre_mode at 0, CR, LF and TAB turn into spaces and runs of spaces collapse to one; with
// pre_mode at 1, line breaks are kept and a CR becomes LF unless an LF is next to it, which
// means a CR is held back until the following character decides it. References of the form
// &#digits; are decoded modulo 2^16, and a value of zero produces nothing. Each input
// character yields zero, one or two results; a string end always yields at least one, a bare
// marker with tuser low and tdata zero when there is no text, and tlast marks the last result
// of the string. A character is decoded in the cycle it is accepted and its results sit in a
// three-entry output queue the next cycle. in_tready is high whenever that queue holds at most
// one result, so one character is taken every cycle while results drain one per cycle; a
// character that yields two results leaves an extra result in the queue, which then holds
// off input until it has drained. pre_mode is read and written at byte address 0 on
// the APB-style port and must only be written while the block is idle. No clearing pass is
// needed after reset.
module text_space_collapse_char_ref_decode
  import tscd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,

  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [CharW-1:0] in_tdata,   // [15:0] in_char
  input  wire logic             in_tlast,

  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [CharW-1:0]      out_tdata,  // [15:0] out_char
  output logic [0:0]            out_tuser,  // [0] char_valid
  output logic                  out_tlast,

  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [2:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  dec_state_t st_r;
  dec_state_t st_nxt;
  logic       pre_mode_r;
  core_out_t  core_res;
  logic       in_fire;
  logic       out_fire;
  logic       cfg_wr;
  logic [1:0] q_cnt;
  res_t       q_head;

  // Configuration port: always ready, one register at address 0.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_PRE_MODE) ? {31'd0, pre_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_mode_r <= 1'b0;
    end else if (cfg_wr && (cfg_paddr[2] == REG_PRE_MODE)) begin
      pre_mode_r <= cfg_pwdata[0];
    end
  end

  // Input is taken while the queue has room for the two results a character may produce.
  assign in_tready = !q_cnt[1];
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  tscd_char_core u_core (
    .st      (st_r),
    .in_char (in_tdata),
    .eos     (in_tlast),
    .pre     (pre_mode_r),
    .st_nxt  (st_nxt),
    .res     (core_res)
  );

  // Decoder state advances only on an accepted character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_TEXT, code: '0, prev_lf: 1'b0, space_seen: 1'b0, cr_pend: 1'b0};
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  tscd_res_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .push_res (core_res),
    .pop      (out_fire),
    .cnt      (q_cnt),
    .head     (q_head)
  );

  assign out_tvalid   = (q_cnt != 2'd0);
  assign out_tdata    = q_head.ch;
  assign out_tuser[0] = q_head.vld;
  assign out_tlast    = q_head.last;

`ifndef SYNTHESIS
  // The queue never holds more than its three entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt != 2'd3 || !in_fire)
    else $error("character accepted with a full result queue");

  // A bare end marker carries no character and always closes the string.
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && (out_tdata == '0)))
    else $error("result without a character is not a clean end marker");

  // A string end wipes all per-string state.
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> ((st_r.phase == PH_TEXT) && (st_r.code == '0) &&
                               !st_r.space_seen && !st_r.cr_pend && !st_r.prev_lf))
    else $error("decoder state survived the end of a string");

  // A held-back CR is only ever left by a CR that did not follow an LF.
  a_cr_pend_no_lf: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cr_pend |-> !st_r.prev_lf)
    else $error("CR held back while the previous character was LF");

  // Every string end puts at least one result into the queue.
  a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (q_cnt != 2'd0))
    else $error("string end produced no result");
`endif

endmodule

`default_nettype wire

// ----- src/tscd_char_core.sv -----
// Combinational decode of one character: next state and up to two results.
`default_nettype none

module tscd_char_core
  import tscd_pkg::*;
(
  input  wire dec_state_t         st,
  input  wire logic [CharW-1:0]   in_char,
  input  wire logic               eos,
  input  wire logic               pre,
  output dec_state_t              st_nxt,
  output core_out_t               res
);

  logic [CharW-1:0] t;
  logic             pend_emit;
  logic             main_emit;
  logic [CharW-1:0] main_char;
  logic [CharW-1:0] code_x10;
  dec_state_t       nx;
  core_out_t        o;

  // Multiply by ten as two shifts and an add; digits map to their low nibble.
  assign code_x10 = {st.code[CharW-4:0], 3'b000} + {st.code[CharW-2:0], 1'b0};

  always_comb begin
    t         = in_char;
    nx        = st;
    nx.cr_pend = 1'b0;
    main_emit = 1'b0;
    pend_emit = st.cr_pend && (in_char != CH_LF);

    if (!pre && (in_char inside {CH_CR, CH_LF, CH_TAB})) begin
      t = CH_SPACE;
    end
    main_char = t;

    if (t == CH_CR) begin
      if (!st.prev_lf) begin
        if (eos) begin
          main_emit = 1'b1;
          main_char = CH_LF;
        end else begin
          nx.cr_pend = 1'b1;
        end
      end
    end else if (t == CH_LF) begin
      main_emit = 1'b1;
    end else if (t == CH_AMP) begin
      nx.phase = PH_AMP;
      nx.code  = '0;
    end else if (st.phase == PH_TEXT) begin
      if (t == CH_SPACE) begin
        main_emit     = pre || !st.space_seen;
        nx.space_seen = 1'b1;
      end else begin
        main_emit     = 1'b1;
        nx.space_seen = 1'b0;
      end
    end else begin
      if ((st.phase == PH_HASH) && (t inside {[CH_ZERO:CH_NINE]})) begin
        nx.code = code_x10 + {12'd0, t[3:0]};
      end else if ((t == CH_HASH) && (st.phase == PH_AMP)) begin
        nx.phase = PH_HASH;
      end else if (t == CH_SEMI) begin
        main_emit     = (st.code != '0);
        main_char     = st.code;
        nx.phase      = PH_TEXT;
        nx.space_seen = 1'b0;
      end else begin
        nx.phase = PH_TEXT;
      end
    end
    nx.prev_lf = (t == CH_LF);

    o = '0;
    if (pend_emit) begin
      o.r0 = '{ch: CH_LF, vld: 1'b1, last: 1'b0};
      o.r1 = '{ch: main_char, vld: 1'b1, last: 1'b0};
      o.n  = main_emit ? 2'd2 : 2'd1;
    end else begin
      o.r0 = '{ch: main_char, vld: 1'b1, last: 1'b0};
      o.n  = main_emit ? 2'd1 : 2'd0;
    end

    if (eos) begin
      // A string end always yields at least a bare marker, and the final result carries last.
      if (o.n == 2'd0) begin
        o.r0 = '{ch: '0, vld: 1'b0, last: 1'b1};
        o.n  = 2'd1;
      end else if (o.n == 2'd1) begin
        o.r0.last = 1'b1;
      end else begin
        o.r1.last = 1'b1;
      end
      nx = '{phase: PH_TEXT, code: '0, prev_lf: 1'b0, space_seen: 1'b0, cr_pend: 1'b0};
    end

    st_nxt = nx;
    res    = o;
  end

endmodule

`default_nettype wire

// ----- src/tscd_res_queue.sv -----
// Three-entry shifting result queue that takes up to two results per cycle.
`default_nettype none

module tscd_res_queue
  import tscd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire core_out_t  push_res,
  input  wire logic       pop,
  output logic [1:0]      cnt,
  output res_t            head
);

  res_t       q_r   [QueueDepth];
  res_t       q_nxt [QueueDepth];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] base;
  logic [1:0] push_n;

  assign push_n = push ? push_res.n : 2'd0;
  assign base   = cnt_r - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      if (pop && (i < QueueDepth - 1)) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((push_n != 2'd0) && (2'(i) == base)) begin
        q_nxt[i] = push_res.r0;
      end
      if ((push_n == 2'd2) && (2'(i) == base + 2'd1)) begin
        q_nxt[i] = push_res.r1;
      end
    end
    cnt_nxt = base + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign cnt  = cnt_r;
  assign head = q_r[0];

endmodule

`default_nettype wire

// ----- tb/tb_text_space_collapse_char_ref_decode.sv -----
// Self-checking testbench for the text space collapse and character reference decoder.
`timescale 1ns / 1ps

module tb_text_space_collapse_char_ref_decode
  import tscd_pkg::*;
();

  // Byte addresses on the configuration port. Only pre_mode exists; the spare address
  // is written to prove that a write outside the register map changes nothing.
  localparam logic [2:0] PreModeAddr = 3'(4 * REG_PRE_MODE);
  localparam logic [2:0] SpareAddr   = 3'd4;
  localparam res_t       NoRes       = '0;

  // One row of the directed table. When typed is set, res is the single result the row
  // must produce; otherwise the predictor supplies whatever the row is expected to give.
  typedef struct packed {
    logic             pre;
    logic [CharW-1:0] ch;
    logic             eos;
    logic             typed;
    res_t             res;
  } dir_row_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [CharW-1:0] in_tdata    = '0;   // [15:0] in_char
  logic             in_tlast    = 1'b0;
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [CharW-1:0] out_tdata;          // [15:0] out_char
  logic [0:0]       out_tuser;          // [0] char_valid
  logic             out_tlast;
  logic             cfg_psel    = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite  = 1'b0;
  logic [2:0]       cfg_paddr   = '0;
  logic [31:0]      cfg_pwdata  = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  // Copies of the block's outputs (and of our own ready) taken at the falling edge. Every
  // signal is stable by then, so the values seen here are exactly the ones that the next
  // rising edge acts on, whatever order the simulator runs processes in at that edge.
  logic             in_rdy_s, out_vld_s, out_rdy_s, out_last_s, out_user_s, pready_s;
  logic [CharW-1:0] out_data_s;
  logic [31:0]      prdata_s;

  // Predictor state: a private copy of the block's register and decoder state.
  logic             pre_mode_m;
  phase_t           phase_m;
  logic [CharW-1:0] code_m;
  logic             prev_lf_m, space_m, cr_pend_m;

  res_t             text_expect_q [$];
  int               error_count = 0;
  bit               idle_en     = 1'b1;
  logic [CharW-1:0] ws_chars [0:3] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
  dir_row_t         dir_table [0:25];

  text_space_collapse_char_ref_decode i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    in_rdy_s   <= in_tready;
    out_vld_s  <= out_tvalid;
    out_rdy_s  <= out_tready;
    out_data_s <= out_tdata;
    out_user_s <= out_tuser[0];
    out_last_s <= out_tlast;
    prdata_s   <= cfg_prdata;
    pready_s   <= cfg_pready;
  end

  task automatic flag_error(input string what);
    if (error_count < 50) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    error_count++;
  endtask

  // Works out what one character does to the decoder state and queues the results it
  // causes, oldest first. Returns how many results were queued.
  function automatic int predict_text(input logic [CharW-1:0] ch, input logic eos);
    logic [CharW-1:0] t;
    res_t             outs [0:1];
    int               n;
    t = ch;
    n = 0;
    // A CR held back from the previous character turns into LF now, unless this
    // character is itself the LF that makes the pair.
    if (cr_pend_m) begin
      cr_pend_m = 1'b0;
      if (ch != CH_LF) begin
        outs[n] = '{CH_LF, 1'b1, 1'b0};
        n++;
      end
    end
    if (!pre_mode_m && (t == CH_CR || t == CH_LF || t == CH_TAB)) begin
      t = CH_SPACE;
    end
    if (t == CH_CR) begin
      if (!prev_lf_m) begin
        if (eos) begin
          outs[n] = '{CH_LF, 1'b1, 1'b0};
          n++;
        end else begin
          cr_pend_m = 1'b1;
        end
      end
    end else if (t == CH_LF) begin
      outs[n] = '{CH_LF, 1'b1, 1'b0};
      n++;
    end else if (t == CH_AMP) begin
      phase_m = PH_AMP;
      code_m  = '0;
    end else if (phase_m == PH_TEXT) begin
      // Plain text. Spaces collapse unless line breaks are being kept.
      if (t == CH_SPACE) begin
        if (pre_mode_m || !space_m) begin
          outs[n] = '{t, 1'b1, 1'b0};
          n++;
        end
        space_m = 1'b1;
      end else begin
        outs[n] = '{t, 1'b1, 1'b0};
        n++;
        space_m = 1'b0;
      end
    end else if (phase_m == PH_HASH && t >= CH_ZERO && t <= CH_NINE) begin
      code_m = code_m * 16'd10 + (t - CH_ZERO);
    end else if (t == CH_HASH && phase_m == PH_AMP) begin
      phase_m = PH_HASH;
    end else if (t == CH_SEMI) begin
      // A reference that adds up to zero is swallowed but still ends a space run.
      if (code_m != '0) begin
        outs[n] = '{code_m, 1'b1, 1'b0};
        n++;
      end
      phase_m = PH_TEXT;
      space_m = 1'b0;
    end else begin
      // Anything else breaks the reference and is itself dropped.
      phase_m = PH_TEXT;
    end
    prev_lf_m = (t == CH_LF);
    if (eos) begin
      if (n == 0) begin
        outs[0] = '{16'h0000, 1'b0, 1'b0};
        n = 1;
      end
      outs[n-1].last = 1'b1;
      phase_m   = PH_TEXT;
      code_m    = '0;
      prev_lf_m = 1'b0;
      space_m   = 1'b0;
      cr_pend_m = 1'b0;
    end
    for (int k = 0; k < n; k++) begin
      text_expect_q.push_back(outs[k]);
    end
    return n;
  endfunction

  // Offers one character, idling at random first, and returns right after the rising
  // edge at which the transfer took place.
  task automatic drive_char(input logic [CharW-1:0] ch, input logic eos);
    while (idle_en && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_rdy_s);
  endtask

  // Lets every expected result come out, then a few more cycles so that a character
  // that produced nothing has surely left the pipeline before the block is touched.
  task automatic drain_results(input int settle);
    in_tvalid <= 1'b0;
    while (text_expect_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!pready_s);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == PreModeAddr) begin
      pre_mode_m = value[0];
    end
    @(posedge clk);
  endtask

  // Reads pre_mode back and compares it with the value the predictor holds.
  task automatic cfg_check();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= PreModeAddr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!pready_s);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (prdata_s !== {31'b0, pre_mode_m}) begin
      flag_error($sformatf("pre_mode read back %h, expected %0d", prdata_s, pre_mode_m));
    end
    @(posedge clk);
  endtask

  // Result side: every accepted transfer is checked field by field against the oldest
  // expectation, and the ready is redrawn for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_vld_s && out_rdy_s) begin
      if (text_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected result char %h valid %0d last %0d",
                             out_data_s, out_user_s, out_last_s));
      end else begin
        if (out_data_s !== text_expect_q[0].ch) begin
          flag_error($sformatf("out_char %h, expected %h", out_data_s, text_expect_q[0].ch));
        end
        if (out_user_s !== text_expect_q[0].vld) begin
          flag_error($sformatf("char_valid %0d, expected %0d (char %h)",
                               out_user_s, text_expect_q[0].vld, text_expect_q[0].ch));
        end
        if (out_last_s !== text_expect_q[0].last) begin
          flag_error($sformatf("last %0d, expected %0d (char %h)",
                               out_last_s, text_expect_q[0].last, text_expect_q[0].ch));
        end
        void'(text_expect_q.pop_front());
      end
    end
    out_tready <= idle_en ? ($urandom_range(99) >= 20) : 1'b1;
  end

  // Hard limit for a hung run; a clean run needs well under a tenth of it.
  initial begin
    #2_000_000;
    $display("tb_text_space_collapse_char_ref_decode: done, errors");
    $finish;
  end

  initial begin
    logic [CharW-1:0] str_q [$];
    int               sent;
    int               pick;
    int               n;

    pre_mode_m = 1'b0;
    phase_m    = PH_TEXT;
    code_m     = '0;
    prev_lf_m  = 1'b0;
    space_m    = 1'b0;
    cr_pend_m  = 1'b0;

    // Directed rows: basic text, the extreme character codes, a restarted reference,
    // a reference that wraps past 2^16, a zero reference at the end of a string, and
    // in preformatted mode the CR cases (resolved by the next character, absorbed by a
    // following LF, dropped after an LF, decided at once at the end of a string and
    // taken as a line break inside a reference) plus a broken reference.
    dir_table = '{
      '{1'b0, 16'h0041,          1'b0, 1'b1, '{16'h0041, 1'b1, 1'b1 ^ 1'b1}},
      '{1'b0, CH_TAB,            1'b0, 1'b0, NoRes},
      '{1'b0, 16'hFFFF,          1'b1, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
      '{1'b0, CH_AMP,            1'b0, 1'b0, NoRes},
      '{1'b0, CH_AMP,            1'b0, 1'b0, NoRes},
      '{1'b0, CH_HASH,           1'b0, 1'b0, NoRes},
      '{1'b0, CH_ZERO + 16'd6,   1'b0, 1'b0, NoRes},
      '{1'b0, CH_ZERO + 16'd5,   1'b0, 1'b0, NoRes},
      '{1'b0, CH_ZERO + 16'd5,   1'b0, 1'b0, NoRes},
      '{1'b0, CH_ZERO + 16'd3,   1'b0, 1'b0, NoRes},
      '{1'b0, CH_ZERO + 16'd7,   1'b0, 1'b0, NoRes},
      '{1'b0, CH_SEMI,           1'b0, 1'b0, NoRes},
      '{1'b0, CH_AMP,            1'b0, 1'b0, NoRes},
      '{1'b0, CH_HASH,           1'b0, 1'b0, NoRes},
      '{1'b0, CH_ZERO,           1'b0, 1'b0, NoRes},
      '{1'b0, CH_SEMI,           1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
      '{1'b0, 16'h0000,          1'b1, 1'b1, '{16'h0000, 1'b1, 1'b1}},
      '{1'b1, CH_CR,             1'b0, 1'b0, NoRes},
      '{1'b1, 16'h0061,          1'b0, 1'b0, NoRes},
      '{1'b1, CH_CR,             1'b0, 1'b0, NoRes},
      '{1'b1, CH_LF,             1'b0, 1'b0, NoRes},
      '{1'b1, CH_CR,             1'b0, 1'b0, NoRes},
      '{1'b1, CH_AMP,            1'b0, 1'b0, NoRes},
      '{1'b1, CH_CR,             1'b1, 1'b1, '{CH_LF, 1'b1, 1'b1}},
      '{1'b1, CH_AMP,            1'b0, 1'b0, NoRes},
      '{1'b1, 16'h0078,          1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check();

    for (int i = 0; i < $size(dir_table); i++) begin
      if (dir_table[i].pre != pre_mode_m) begin
        drain_results(4);
        cfg_write(PreModeAddr, {31'b0, dir_table[i].pre});
        // A write past the only register must leave pre_mode alone.
        cfg_write(SpareAddr, {31'b0, ~dir_table[i].pre});
        cfg_check();
      end
      n = predict_text(dir_table[i].ch, dir_table[i].eos);
      if (dir_table[i].typed) begin
        repeat (n) void'(text_expect_q.pop_back());
        text_expect_q.push_back(dir_table[i].res);
      end
      drive_char(dir_table[i].ch, dir_table[i].eos);
    end
    drain_results(4);

    // Random phases, each under its own pre_mode and ending on a string boundary so that
    // the register only changes while the decoder is idle. One phase runs with no idling
    // on either side to keep the block at full rate for a long stretch.
    for (int ph = 0; ph < 8; ph++) begin
      idle_en = (ph != 3);
      cfg_write(PreModeAddr, {31'b0, (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(1))});
      cfg_check();
      sent = 0;
      while (sent < 204) begin
        // Build one string from a few tokens: mostly text, whitespace runs and well-formed
        // references with random digits, plus broken references and line break pairs.
        str_q.delete();
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(99);
          if (pick < 30) begin
            str_q.push_back(16'($urandom_range(16'h21, 16'h7E)));
          end else if (pick < 45) begin
            repeat ($urandom_range(1, 3)) str_q.push_back(ws_chars[$urandom_range(3)]);
          end else if (pick < 65) begin
            str_q.push_back(CH_AMP);
            str_q.push_back(CH_HASH);
            if ($urandom_range(9) == 0) begin
              str_q.push_back(ws_chars[$urandom_range(2, 3)]);
            end
            repeat ($urandom_range(1, 6)) str_q.push_back(CH_ZERO + 16'($urandom_range(9)));
            str_q.push_back(CH_SEMI);
          end else if (pick < 75) begin
            str_q.push_back(CH_AMP);
            if ($urandom_range(1)) begin
              str_q.push_back(CH_HASH);
            end
            repeat ($urandom_range(2)) str_q.push_back(CH_ZERO + 16'($urandom_range(9)));
            case ($urandom_range(3))
              0:       str_q.push_back(CH_SEMI);
              1:       str_q.push_back(CH_AMP);
              2:       str_q.push_back(CH_HASH);
              default: str_q.push_back(16'($urandom_range(16'hFFFF)));
            endcase
          end else if (pick < 85) begin
            str_q.push_back(ws_chars[$urandom_range(2, 3)]);
            str_q.push_back(ws_chars[$urandom_range(2, 3)]);
          end else begin
            str_q.push_back(16'($urandom_range(16'hFFFF)));
          end
        end
        for (int k = 0; k < str_q.size(); k++) begin
          void'(predict_text(str_q[k], k == str_q.size() - 1));
          drive_char(str_q[k], k == str_q.size() - 1);
        end
        sent += str_q.size();
      end
      drain_results(4);
    end

    // Nothing is expected any more; give the block time to show a stray result.
    idle_en = 1'b1;
    drain_results(16);
    if (error_count == 0) begin
      $display("tb_text_space_collapse_char_ref_decode: done, clean");
    end else begin
      $display("tb_text_space_collapse_char_ref_decode: done, errors");
    end
    $finish;
  end

endmodule
